FILE: rtl/core/spib_pkg.sv
package spib_pkg;

    localparam int MAX_PREFIX_LEN = 6;
    localparam int POSITION_BITS  = 24;

    localparam int TABLE_SIZE   = ((1 << (2 * (MAX_PREFIX_LEN + 1))) - 4) / 3;
    localparam int ADDR_BITS    = $clog2(TABLE_SIZE);
    localparam int ENTRY_BITS   = POSITION_BITS + 2;
    localparam int N_MARK_BIT   = POSITION_BITS;
    localparam int ABSENT_BIT   = POSITION_BITS + 1;
    localparam int CODE_BITS    = 2 * MAX_PREFIX_LEN;
    localparam int LEVEL_BITS   = $clog2(MAX_PREFIX_LEN + 1);
    localparam int LVL_IDX_BITS = (MAX_PREFIX_LEN > 1) ? $clog2(MAX_PREFIX_LEN) : 1;

    localparam logic [2:0] PREFIX_LENGTH_RESET = 3'd6;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [23:0] sa_index;
        logic [11:0] prefix_code;
        logic [2:0]  n_level;
        logic [12:0] read_address;
    } spib_item_t;

    typedef struct packed {
        logic [23:0] entry_position;
        logic        entry_absent;
        logic        entry_n_mark;
        logic        order_error;
    } spib_result_t;

    typedef struct packed {
        logic                  wr_en;
        logic [ADDR_BITS-1:0]  wr_addr;
        logic [ENTRY_BITS-1:0] wr_data;
        logic                  rd_en;
        logic [ADDR_BITS-1:0]  rd_addr;
    } spib_mem_req_t;

    // first table entry of a level: sum of 4^(i+1) over the levels below
    function automatic logic [ADDR_BITS-1:0] level_base(input logic [LEVEL_BITS-1:0] lvl);
        logic [ADDR_BITS-1:0] sum;
        sum = '0;
        for (int i = 0; i < MAX_PREFIX_LEN; i++)
        begin
            if (LEVEL_BITS'(i) < lvl)
            begin
                sum = sum + ADDR_BITS'(1 << (2 * i + 2));
            end
        end
        return sum;
    endfunction

endpackage

FILE: rtl/core/spib_table.sv
module spib_table (
    input  logic                                clk,
    input  spib_pkg::spib_mem_req_t             req,
    output logic [spib_pkg::ENTRY_BITS-1:0]     rd_data
);

    logic [spib_pkg::ENTRY_BITS-1:0] mem [spib_pkg::TABLE_SIZE];
    logic [spib_pkg::ENTRY_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/spib_ctrl.sv
module spib_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  spib_pkg::spib_item_t                item,
    input  logic [2:0]                          prefix_length,
    output logic                                res_valid,
    input  logic                                res_ready,
    output spib_pkg::spib_result_t              res,
    output spib_pkg::spib_mem_req_t             mem_req,
    input  logic [spib_pkg::ENTRY_BITS-1:0]     rd_data
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_LEVEL    = 3'd2;
    localparam logic [2:0] S_FILL     = 3'd3;
    localparam logic [2:0] S_NMARK_RD = 3'd4;
    localparam logic [2:0] S_NMARK_WR = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    localparam int LB = spib_pkg::LEVEL_BITS;
    localparam int CB = spib_pkg::CODE_BITS;
    localparam int AB = spib_pkg::ADDR_BITS;
    localparam int PB = spib_pkg::POSITION_BITS;
    localparam int EB = spib_pkg::ENTRY_BITS;
    localparam int LVL_IDX_BITS_W = spib_pkg::LVL_IDX_BITS;

    logic [2:0]    state_reg, state_next;
    logic [AB-1:0] clr_addr_reg, clr_addr_next;
    logic [LB-1:0] lvl_reg, lvl_next;
    logic [LB-1:0] len_reg, len_next;
    logic [LB-1:0] nlev_reg, nlev_next;
    logic [CB-1:0] code_reg, code_next;
    logic [PB-1:0] pos_reg, pos_next;
    logic [CB-1:0] fill_reg, fill_next;
    logic [CB-1:0] pref_reg, pref_next;
    logic [AB-1:0] nm_addr_reg, nm_addr_next;
    logic          err_reg, err_next;
    logic          is_read_reg, is_read_next;
    logic          hit_reg, hit_next;

    logic [CB-1:0] last_code_reg [spib_pkg::MAX_PREFIX_LEN];
    logic [spib_pkg::MAX_PREFIX_LEN-1:0] level_valid_reg, level_valid_next;
    logic          last_we;
    logic [CB-1:0] last_wdata;

    logic [LB-1:0]           len_c;
    logic [CB-1:0]           code_mask;
    logic [LB-1:0]           lvl_gap;
    logic [CB-1:0]           pref;
    logic [LVL_IDX_BITS_W-1:0] lvl_idx;
    logic [AB-1:0]           base;
    logic                    accept;

    assign lvl_idx    = lvl_reg[LVL_IDX_BITS_W-1:0];
    assign base       = spib_pkg::level_base(lvl_reg);
    assign lvl_gap    = len_reg - lvl_reg - LB'(1);
    assign pref       = code_reg >> {lvl_gap, 1'b0};
    assign item_stall = (state_reg != S_IDLE);
    assign accept     = item_valid && !item_stall;

    // clamp the configured length to 1..MAX_PREFIX_LEN
    always_comb
    begin
        if (prefix_length == 3'd0)
        begin
            len_c = LB'(1);
        end
        else if (LB'(prefix_length) > LB'(spib_pkg::MAX_PREFIX_LEN))
        begin
            len_c = LB'(spib_pkg::MAX_PREFIX_LEN);
        end
        else
        begin
            len_c = LB'(prefix_length);
        end
    end

    assign code_mask = ~({CB{1'b1}} << {len_c, 1'b0});

    always_comb
    begin
        state_next       = state_reg;
        clr_addr_next    = clr_addr_reg;
        lvl_next         = lvl_reg;
        len_next         = len_reg;
        nlev_next        = nlev_reg;
        code_next        = code_reg;
        pos_next         = pos_reg;
        fill_next        = fill_reg;
        pref_next        = pref_reg;
        nm_addr_next     = nm_addr_reg;
        err_next         = err_reg;
        is_read_next     = is_read_reg;
        hit_next         = hit_reg;
        level_valid_next = level_valid_reg;
        last_we          = 1'b0;
        last_wdata       = pref;
        mem_req          = '0;
        res_valid        = 1'b0;
        res              = '0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = clr_addr_reg;
                mem_req.wr_data = '0;
                clr_addr_next   = clr_addr_reg + AB'(1);
                if (clr_addr_reg == AB'(spib_pkg::TABLE_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    len_next     = len_c;
                    nlev_next    = LB'(item.n_level);
                    code_next    = CB'(item.prefix_code) & code_mask;
                    pos_next     = PB'(item.sa_index);
                    lvl_next     = '0;
                    err_next     = 1'b0;
                    is_read_next = (item.kind == spib_pkg::KIND_READ);
                    hit_next     = 1'b0;
                    if (item.kind == spib_pkg::KIND_READ)
                    begin
                        if (32'(item.read_address) < 32'(spib_pkg::TABLE_SIZE))
                        begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = AB'(item.read_address);
                            hit_next        = 1'b1;
                        end
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        state_next = S_LEVEL;
                    end
                end
            end

            S_LEVEL:
            begin
                if (lvl_reg >= len_reg)
                begin
                    state_next = S_RESULT;
                end
                else if (lvl_reg >= nlev_reg)
                begin
                    state_next = S_NMARK_RD;
                end
                else if (!level_valid_reg[lvl_idx] || pref > last_code_reg[lvl_idx])
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = base + AB'(pref);
                    mem_req.wr_data = EB'(pos_reg);
                    fill_next       = level_valid_reg[lvl_idx] ?
                                      last_code_reg[lvl_idx] + CB'(1) : '0;
                    pref_next       = pref;
                    last_we         = 1'b1;
                    level_valid_next[lvl_idx] = 1'b1;
                    if (fill_next != pref)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        lvl_next = lvl_reg + LB'(1);
                    end
                end
                else
                begin
                    if (pref < last_code_reg[lvl_idx])
                    begin
                        err_next = 1'b1;
                    end
                    lvl_next = lvl_reg + LB'(1);
                end
            end

            // skipped prefixes get the position with the absent mark
            S_FILL:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = base + AB'(fill_reg);
                mem_req.wr_data = EB'(pos_reg);
                mem_req.wr_data[spib_pkg::ABSENT_BIT] = 1'b1;
                fill_next       = fill_reg + CB'(1);
                if (fill_next == pref_reg)
                begin
                    lvl_next   = lvl_reg + LB'(1);
                    state_next = S_LEVEL;
                end
            end

            S_NMARK_RD:
            begin
                if (lvl_reg >= len_reg)
                begin
                    state_next = S_RESULT;
                end
                else if (level_valid_reg[lvl_idx])
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = base + AB'(last_code_reg[lvl_idx]);
                    nm_addr_next    = mem_req.rd_addr;
                    state_next      = S_NMARK_WR;
                end
                else
                begin
                    lvl_next = lvl_reg + LB'(1);
                end
            end

            // read data of the last recorded entry is back, set its N mark
            S_NMARK_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = nm_addr_reg;
                mem_req.wr_data = rd_data;
                mem_req.wr_data[spib_pkg::N_MARK_BIT] = 1'b1;
                lvl_next        = lvl_reg + LB'(1);
                state_next      = S_NMARK_RD;
            end

            S_RESULT:
            begin
                res_valid = 1'b1;
                if (is_read_reg && hit_reg)
                begin
                    res.entry_position = 24'(rd_data[PB-1:0]);
                    res.entry_absent   = rd_data[spib_pkg::ABSENT_BIT];
                    res.entry_n_mark   = rd_data[spib_pkg::N_MARK_BIT];
                end
                res.order_error = !is_read_reg && err_reg;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_addr_reg    <= '0;
            level_valid_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_addr_reg    <= clr_addr_next;
            level_valid_reg <= level_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg     <= lvl_next;
        len_reg     <= len_next;
        nlev_reg    <= nlev_next;
        code_reg    <= code_next;
        pos_reg     <= pos_next;
        fill_reg    <= fill_next;
        pref_reg    <= pref_next;
        nm_addr_reg <= nm_addr_next;
        err_reg     <= err_next;
        is_read_reg <= is_read_next;
        hit_reg     <= hit_next;
        if (last_we)
        begin
            last_code_reg[lvl_idx] <= last_wdata;
        end
    end

    a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        mem_req.wr_en && mem_req.rd_en |-> mem_req.wr_addr != mem_req.rd_addr)
        else $error("table read and write hit the same entry in one cycle");

    a_fill_below_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FILL |-> fill_reg < pref_reg)
        else $error("absent fill ran past the recorded prefix");

    a_nmark_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_NMARK_RD && mem_req.rd_en |=> state_reg == S_NMARK_WR)
        else $error("n mark read not followed by its write back");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE || state_reg == S_RESULT |-> !mem_req.wr_en)
        else $error("table written while no record is in progress");

endmodule

FILE: rtl/core/suffix_prefix_index_builder_unit.sv
// Builds a multi-level prefix index over suffix records fed in suffix-array order, and
// returns table entries on read items. The whole index lives in one 5460 x 26 bit table
// memory with a single write port. After reset a clearing pass writes zero to every
// entry before the first item is taken. A record walks the levels in use, writing its
// position at its prefix and an absent-marked position at each skipped prefix, and,
// when an unknown base stops the walk, rewrites the last recorded entry of each
// remaining level in use with an N mark. One result is returned per item, and the next
// item is taken while the previous result still waits in the output register.
module suffix_prefix_index_builder_unit (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  spib_pkg::spib_item_t   item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output spib_pkg::spib_result_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_data
);

    logic [2:0]                      prefix_length_reg;
    logic                            result_valid_reg, result_valid_next;
    spib_pkg::spib_result_t          result_reg;
    logic                            res_valid;
    logic                            res_ready;
    spib_pkg::spib_result_t          res;
    spib_pkg::spib_mem_req_t         mem_req;
    logic [spib_pkg::ENTRY_BITS-1:0] rd_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_length_reg <= spib_pkg::PREFIX_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            prefix_length_reg <= cfg_data;
        end
    end

    // output register frees when empty or when its transfer completes
    assign res_ready = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_valid && res_ready)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    spib_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .item          (item),
        .prefix_length (prefix_length_reg),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

    spib_table u_table (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

endmodule

FILE: tb/prefix_index_checker.sv
module prefix_index_checker
    import spib_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    input  logic         item_stall,
    input  spib_item_t   item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  spib_result_t result,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_data,
    output int           pending,
    output int           failures
);

    logic [ENTRY_BITS-1:0] prefix_table [TABLE_SIZE];
    logic [CODE_BITS-1:0]  last_prefix [MAX_PREFIX_LEN];
    logic [MAX_PREFIX_LEN-1:0] level_used;
    logic [2:0]            levels_in_use;
    spib_result_t          expected_entries [$];
    spib_result_t          want;
    int                    error_count = 0;

    task automatic flag_error(input string what);
        error_count++;
        $display("%0t index check: %s", $time, what);
    endtask

    function automatic int first_entry(input int lvl);
        return ((1 << (2 * lvl + 2)) - 4) / 3;
    endfunction

    // updates the local copy of the table and returns the result the item should give
    function automatic spib_result_t apply_to_index(input spib_item_t it);
        spib_result_t         outcome;
        int                   len;
        int                   lvl;
        int                   k;
        int                   i;
        int                   base;
        int                   from;
        logic                 n_hit;
        logic [CODE_BITS-1:0] code;
        logic [CODE_BITS-1:0] pref;
        outcome = '0;
        if (it.kind == KIND_READ)
        begin
            if (it.read_address < TABLE_SIZE)
            begin
                outcome.entry_position = prefix_table[it.read_address][POSITION_BITS-1:0];
                outcome.entry_n_mark   = prefix_table[it.read_address][N_MARK_BIT];
                outcome.entry_absent   = prefix_table[it.read_address][ABSENT_BIT];
            end
            return outcome;
        end
        len = (levels_in_use < 1) ? 1 :
              (levels_in_use > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : int'(levels_in_use);
        code = it.prefix_code & CODE_BITS'((1 << (2 * len)) - 1);
        n_hit = 1'b0;
        for (lvl = 0; lvl < len && !n_hit; lvl++)
        begin
            base = first_entry(lvl);
            if (lvl >= it.n_level)
            begin
                // unknown base from here on: mark the last recorded entry of each level
                for (k = lvl; k < len; k++)
                begin
                    if (level_used[k])
                    begin
                        prefix_table[first_entry(k) + int'(last_prefix[k])][N_MARK_BIT] = 1'b1;
                    end
                end
                n_hit = 1'b1;
            end
            else
            begin
                pref = code >> (2 * (len - 1 - lvl));
                if (!level_used[lvl] || pref > last_prefix[lvl])
                begin
                    from = level_used[lvl] ? int'(last_prefix[lvl]) + 1 : 0;
                    prefix_table[base + int'(pref)] = ENTRY_BITS'(it.sa_index);
                    for (i = from; i < int'(pref); i++)
                    begin
                        prefix_table[base + i] = {1'b1, 1'b0, it.sa_index};
                    end
                    last_prefix[lvl] = pref;
                    level_used[lvl]  = 1'b1;
                end
                else if (pref < last_prefix[lvl])
                begin
                    outcome.order_error = 1'b1;
                end
            end
        end
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < TABLE_SIZE; a++)
            begin
                prefix_table[a] = '0;
            end
            for (int l = 0; l < MAX_PREFIX_LEN; l++)
            begin
                last_prefix[l] = '0;
            end
            level_used    = '0;
            levels_in_use = PREFIX_LENGTH_RESET;
            expected_entries.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                levels_in_use = cfg_data;
            end
            if (result_valid && !result_stall)
            begin
                if (expected_entries.size() == 0)
                begin
                    flag_error($sformatf("result %h arrived with no item outstanding", result));
                end
                else
                begin
                    want = expected_entries.pop_front();
                    if (result.entry_position !== want.entry_position)
                    begin
                        flag_error($sformatf("entry_position %h, expected %h",
                                             result.entry_position, want.entry_position));
                    end
                    if (result.entry_absent !== want.entry_absent)
                    begin
                        flag_error($sformatf("entry_absent %b, expected %b",
                                             result.entry_absent, want.entry_absent));
                    end
                    if (result.entry_n_mark !== want.entry_n_mark)
                    begin
                        flag_error($sformatf("entry_n_mark %b, expected %b",
                                             result.entry_n_mark, want.entry_n_mark));
                    end
                    if (result.order_error !== want.order_error)
                    begin
                        flag_error($sformatf("order_error %b, expected %b",
                                             result.order_error, want.order_error));
                    end
                end
            end
            if (item_valid && !item_stall)
            begin
                expected_entries.push_back(apply_to_index(item));
            end
            pending  <= expected_entries.size();
            failures <= error_count;
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;

    import spib_pkg::*;

    localparam int QUIET_LIMIT     = 60000;
    localparam int HOLD_CYCLES     = 300;
    localparam int ITEMS_PER_PHASE = 166;
    localparam int NUM_PHASES      = 8;

    logic         clk;
    logic         rst_n;
    logic         item_valid;
    logic         item_stall;
    spib_item_t   item;
    logic         result_valid;
    logic         result_stall;
    spib_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_data;

    int pending;
    int failures;
    int quiet = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_granted = 0;
    int hold_left = 0;
    int cursor;
    int eff_len;
    logic [23:0] next_pos;

    suffix_prefix_index_builder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    prefix_index_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .failures     (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ends the run if no transfer happens on any channel for too long
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
            (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("[suffix_prefix_index_builder_unit] ERROR");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off whenever one is requested
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_granted != hold_asked)
            begin
                hold_left    = HOLD_CYCLES;
                hold_granted = hold_asked;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic spib_item_t make_item(input logic kind, input logic [23:0] pos,
                                             input logic [11:0] code, input logic [2:0] nlev,
                                             input logic [12:0] addr);
        spib_item_t it;
        it.kind         = kind;
        it.sa_index     = pos;
        it.prefix_code  = code;
        it.n_level      = nlev;
        it.read_address = addr;
        return it;
    endfunction

    task automatic send_item(input spib_item_t it);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
    endtask

    // wait until every result is back and the block has gone quiet
    task automatic settle(input int extra);
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_prefix_length(input logic [2:0] value);
        settle(16);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        eff_len = (value < 1) ? 1 : (value > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN : int'(value);
    endtask

    initial
    begin
        logic [2:0]  phase_len [NUM_PHASES];
        logic [12:0] addr;
        logic [11:0] code;
        logic [11:0] keep_mask;
        logic [2:0]  nlev;
        logic [23:0] pos;
        int          lvl;
        int          near;
        int          code_src;

        phase_len = '{3'd1, 3'd0, 3'd3, 3'd7, 3'd2, 3'd5, 3'd4, 3'd6};
        rst_n      <= 1'b0;
        item_valid <= 1'b0;
        item       <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        eff_len    = MAX_PREFIX_LEN;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // cleared table, last entry and addresses past the end
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd0));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'(TABLE_SIZE - 1)));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'(TABLE_SIZE)));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'h1fff));
        // first record on empty levels, then an equal code
        send_item(make_item(KIND_RECORD, 24'h000000, 12'h000, 3'd7, '0));
        send_item(make_item(KIND_RECORD, 24'hffffff, 12'h000, 3'd6, '0));
        // skipped prefixes get the absent mark, then a smaller code
        send_item(make_item(KIND_RECORD, 24'h000101, 12'h005, 3'd6, '0));
        send_item(make_item(KIND_RECORD, 24'h000102, 12'h004, 3'd6, '0));
        // unknown base part way, at the first level, and at the last level
        send_item(make_item(KIND_RECORD, 24'habcdef, 12'h010, 3'd3, '0));
        send_item(make_item(KIND_RECORD, 24'h800000, 12'hfff, 3'd0, '0));
        send_item(make_item(KIND_RECORD, 24'h000150, 12'h018, 3'd5, '0));
        foreach (phase_len[p])
        begin
            addr = (p == 0) ? 13'd0 : 13'd4;
        end
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd0));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd4));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd84));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd85));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd341));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd343));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd346));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd1364));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd1366));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'd1369));

        cursor   = 'h018;
        next_pos = 24'h000200;
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_prefix_length(phase_len[p]);
            send_idle_pct = (p < 3) ? 8 : (p < 6) ? 67 : 0;
            recv_idle_pct = (p < 3) ? 67 : (p < 6) ? 8 : 0;
            if (p == 6)
            begin
                hold_asked++;
            end
            repeat (ITEMS_PER_PHASE)
            begin
                if ($urandom_range(99) < 35)
                begin
                    case ($urandom_range(9))
                        0: addr = 13'($urandom_range(8191, TABLE_SIZE));
                        1, 2, 3: addr = 13'($urandom_range(TABLE_SIZE - 1));
                        default:
                        begin
                            // around the entries most recently written at some level
                            lvl  = $urandom_range(MAX_PREFIX_LEN - 1);
                            near = cursor >> (2 * (MAX_PREFIX_LEN - 1 - lvl));
                            near = near - $urandom_range((near < 3) ? near : 3);
                            addr = 13'(int'(level_base(LEVEL_BITS'(lvl))) + near);
                        end
                    endcase
                    send_item(make_item(KIND_READ, 24'($urandom), 12'($urandom),
                                        3'($urandom), addr));
                end
                else
                begin
                    if ($urandom_range(99) < 15)
                    begin
                        // out of order record
                        code_src = cursor - $urandom_range(1, 200);
                        code_src = (code_src < 0) ? 0 : code_src;
                    end
                    else
                    begin
                        cursor   = cursor + $urandom_range(12);
                        cursor   = (cursor > 4095) ? 4095 : cursor;
                        code_src = cursor;
                    end
                    keep_mask = 12'((1 << (2 * eff_len)) - 1);
                    code = (12'(code_src >> (2 * (MAX_PREFIX_LEN - eff_len))) & keep_mask) |
                           (12'($urandom) & ~keep_mask);
                    if ($urandom_range(99) < 70)
                    begin
                        nlev = 3'($urandom_range(7, eff_len));
                    end
                    else
                    begin
                        nlev = 3'($urandom_range(7));
                    end
                    if ($urandom_range(19) == 0)
                    begin
                        pos = 24'($urandom);
                    end
                    else
                    begin
                        next_pos = next_pos + 24'($urandom_range(1, 3));
                        pos      = next_pos;
                    end
                    send_item(make_item(KIND_RECORD, pos, code, nlev, 13'($urandom)));
                end
            end
        end

        // top of the code space, then read back the last entry
        send_item(make_item(KIND_RECORD, 24'hffffff, 12'hfff, 3'd7, '0));
        send_item(make_item(KIND_READ, '0, '0, '0, 13'(TABLE_SIZE - 1)));

        settle(64);
        if (failures == 0 && pending == 0)
        begin
            $display("[suffix_prefix_index_builder_unit] OK");
        end
        else
        begin
            $display("[suffix_prefix_index_builder_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/spib_pkg.sv
rtl/core/spib_table.sv
rtl/core/spib_ctrl.sv
rtl/core/suffix_prefix_index_builder_unit.sv
tb/prefix_index_checker.sv
tb/tb_top.sv
